// ----- hdl/lru_key_value_cache_macros.svh -----
// ----------------------------------------------------------------------------
// lru key-value cache assertion macros
// concurrent checks on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

`ifndef SYNTH

`define LKVC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("lkvc check failed");

`define LKVC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("lkvc check failed");

`else

`define LKVC_ASSERT_IMP(label, ante, cons)
`define LKVC_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ----- hdl/lkvc_pkg.sv -----
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared constants and types of the lru key-value cache
// ----------------------------------------------------------------------------
package lkvc_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int AGE_W   = IDX_W;
	localparam int KEY_W   = 32;
	localparam int DATA_W  = 32;
	localparam int CAP_W   = 5;

	localparam logic [CNT_W-1:0]  ENTRIES_CNT = CNT_W'(ENTRIES);
	localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(ENTRIES - 1);
	localparam logic [CAP_W-1:0]  CAP_RESET   = CAP_W'(16);
	localparam logic [DATA_W-1:0] MISS_VALUE  = '1;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_UPDATE = 3'b100
	} state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic is_get;
		logic rsp_busy;
	} dp_stat_t;

endpackage

// ----- hdl/lkvc_req_if.sv -----
// ----------------------------------------------------------------------------
// lkvc_req_if
// request channel: operation, key and value to store
// ----------------------------------------------------------------------------
interface lkvc_req_if import lkvc_pkg::*; ();

	logic                     valid;
	logic                     ready;
	logic                     cmd;
	logic [KEY_W-1:0]         key;
	logic signed [DATA_W-1:0] write_value;

	modport source (output valid, output cmd, output key, output write_value, input ready);
	modport sink (input valid, input cmd, input key, input write_value, output ready);

endinterface

// ----- hdl/lkvc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// lkvc_rsp_if
// response channel: hit flag and value read
// ----------------------------------------------------------------------------
interface lkvc_rsp_if import lkvc_pkg::*; ();

	logic                     valid;
	logic                     ready;
	logic                     hit;
	logic signed [DATA_W-1:0] read_value;

	modport source (output valid, output hit, output read_value, input ready);
	modport sink (input valid, input hit, input read_value, output ready);

endinterface

// ----- hdl/lkvc_cfg_if.sv -----
// ----------------------------------------------------------------------------
// lkvc_cfg_if
// configuration write channel for the capacity register
// ----------------------------------------------------------------------------
interface lkvc_cfg_if import lkvc_pkg::*; ();

	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] capacity_in_use;

	modport source (output valid, output capacity_in_use, input ready);
	modport sink (input valid, input capacity_in_use, output ready);

endinterface

// ----- hdl/lkvc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lkvc_ctrl
// sequencer: accept a request, scan all entries, commit the update
// ----------------------------------------------------------------------------
module lkvc_ctrl import lkvc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  ctl
);

	state_t state_q;
	state_t state_nxt;

	assign req_ready  = (state_q == ST_IDLE);
	assign ctl.load   = req_valid && req_ready;
	assign ctl.scan   = (state_q == ST_SCAN);
	assign ctl.commit = (state_q == ST_UPDATE) && !(stat.is_get && stat.rsp_busy);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (ctl.load) state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.scan_done) state_nxt = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (ctl.commit) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ----- hdl/lkvc_datapath.sv -----
// ----------------------------------------------------------------------------
// lkvc_datapath
// key and data memories, valid and age flags, scan compare and update
// ----------------------------------------------------------------------------
module lkvc_datapath import lkvc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_cmd,
	input  logic [KEY_W-1:0]         req_key,
	input  logic [DATA_W-1:0]        req_wdata,
	input  logic                     cfg_we,
	input  logic [CAP_W-1:0]         cfg_data,
	input  dp_cmd_t                  ctl,
	output dp_stat_t                 stat,
	input  logic                     rsp_ready,
	output logic                     rsp_valid,
	output logic                     rsp_hit,
	output logic signed [DATA_W-1:0] rsp_rdata
);

	logic [KEY_W-1:0]  key_mem [ENTRIES];
	logic [DATA_W-1:0] data_mem [ENTRIES];

	logic              cmd_q;
	logic [KEY_W-1:0]  key_q;
	logic [DATA_W-1:0] wdata_q;

	logic [CNT_W-1:0]  idx_q;
	logic              issue_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [KEY_W-1:0]  key_rd_s1;
	logic [DATA_W-1:0] data_rd_s1;

	logic              valid_q [ENTRIES];
	logic [AGE_W-1:0]  age_q [ENTRIES];
	logic [CNT_W-1:0]  occ_q;
	logic [CAP_W-1:0]  cap_q;

	logic              hit_q;
	logic [IDX_W-1:0]  slot_q;
	logic [DATA_W-1:0] data_q;
	logic              free_found_q;
	logic [IDX_W-1:0]  free_q;
	logic [IDX_W-1:0]  victim_q;

	logic              rsp_valid_q;
	logic              rsp_hit_q;
	logic [DATA_W-1:0] rsp_data_q;

	logic              scan_issue;
	logic              cur_valid;
	logic [AGE_W-1:0]  cur_age;
	logic [CNT_W-1:0]  occ_m1;
	logic [CNT_W-1:0]  cap_eff;
	logic              evict;
	logic [IDX_W-1:0]  ins_slot;
	logic [IDX_W-1:0]  wr_slot;
	logic [AGE_W-1:0]  touch_age;
	logic              is_put;
	logic              mem_we;

	assign scan_issue = ctl.scan && (idx_q < ENTRIES_CNT);
	assign cur_valid  = valid_q[idx_s1];
	assign cur_age    = age_q[idx_s1];
	assign occ_m1     = occ_q - CNT_W'(1);
	assign is_put     = (op_t'(cmd_q) == OP_PUT);
	assign touch_age  = age_q[slot_q];

	// capacity zero acts as one, above the store acts as full size
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (cap_q > CAP_W'(ENTRIES)) begin
			cap_eff = ENTRIES_CNT;
		end else begin
			cap_eff = CNT_W'(cap_q);
		end
	end

	assign evict    = !hit_q && (occ_q >= cap_eff);
	assign ins_slot = (evict && (!free_found_q || (victim_q < free_q))) ? victim_q : free_q;
	assign wr_slot  = hit_q ? slot_q : ins_slot;
	assign mem_we   = ctl.commit && is_put;

	assign stat.scan_done = issue_s1 && (idx_s1 == LAST_IDX);
	assign stat.is_get    = !is_put;
	assign stat.rsp_busy  = rsp_valid_q && !rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp_hit   = rsp_hit_q;
	assign rsp_rdata = rsp_data_q;

	// request payload
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= req_cmd;
			key_q   <= req_key;
			wdata_q <= req_wdata;
		end
	end

	// memories, read data registered
	always_ff @(posedge clk) begin
		if (scan_issue) begin
			key_rd_s1  <= key_mem[idx_q[IDX_W-1:0]];
			data_rd_s1 <= data_mem[idx_q[IDX_W-1:0]];
			idx_s1     <= idx_q[IDX_W-1:0];
		end
		if (mem_we) begin
			key_mem[wr_slot]  <= key_q;
			data_mem[wr_slot] <= wdata_q;
		end
	end

	// scan counter and compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			issue_s1     <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			slot_q       <= '0;
			free_q       <= '0;
			victim_q     <= '0;
		end else begin
			issue_s1 <= scan_issue;
			if (ctl.load) begin
				idx_q        <= '0;
				hit_q        <= 1'b0;
				free_found_q <= 1'b0;
			end else if (scan_issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (issue_s1) begin
				if (cur_valid && (key_rd_s1 == key_q) && !hit_q) begin
					hit_q  <= 1'b1;
					slot_q <= idx_s1;
				end
				if (!cur_valid && !free_found_q) begin
					free_found_q <= 1'b1;
					free_q       <= idx_s1;
				end
				if (cur_valid && (CNT_W'(cur_age) == occ_m1)) begin
					victim_q <= idx_s1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue_s1 && cur_valid && (key_rd_s1 == key_q) && !hit_q) begin
			data_q <= data_rd_s1;
		end
	end

	// valid flags, ages and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				age_q[i]   <= '0;
			end
			occ_q <= '0;
		end else if (ctl.commit) begin
			if (hit_q) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (valid_q[i] && (age_q[i] < touch_age)) begin
						age_q[i] <= age_q[i] + AGE_W'(1);
					end
				end
				age_q[slot_q] <= '0;
			end else if (is_put) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (evict && (IDX_W'(i) == victim_q)) begin
						valid_q[i] <= 1'b0;
						age_q[i]   <= '0;
					end else if (valid_q[i]) begin
						age_q[i] <= age_q[i] + AGE_W'(1);
					end
				end
				valid_q[ins_slot] <= 1'b1;
				age_q[ins_slot]   <= '0;
				if (!evict) occ_q <= occ_q + CNT_W'(1);
			end
		end
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_data;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.commit && !is_put) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit && !is_put) begin
			rsp_hit_q  <= hit_q;
			rsp_data_q <= hit_q ? data_q : MISS_VALUE;
		end
	end

endmodule

// ----- hdl/lru_key_value_cache.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key-value store with least-recently-used replacement
// one request at a time; a get commit waits while an older response is unread
// the scan reads one key memory entry a cycle over all 16 entries before update
// reset: all entries invalid, occupancy zero, capacity 16, no clearing pass
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_macros.svh"

module lru_key_value_cache import lkvc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	lkvc_req_if.sink   req,
	lkvc_rsp_if.source rsp,
	lkvc_cfg_if.sink   cfg
);

	dp_cmd_t  ctl;
	dp_stat_t stat;

	assign cfg.ready = 1'b1;

	lkvc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	lkvc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_cmd   (req.cmd),
		.req_key   (req.key),
		.req_wdata (req.write_value),
		.cfg_we    (cfg.valid),
		.cfg_data  (cfg.capacity_in_use),
		.ctl       (ctl),
		.stat      (stat),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.rsp_hit   (rsp.hit),
		.rsp_rdata (rsp.read_value)
	);

	// busy once a request is taken
	`LKVC_ASSERT_NXT(a_busy_after_req, req.valid && req.ready, !req.ready)
	// a committed lookup always presents a response
	`LKVC_ASSERT_NXT(a_get_gives_rsp, ctl.commit && stat.is_get, rsp.valid)
	// a response only appears from a committed lookup
	`LKVC_ASSERT_IMP(a_rsp_from_commit, $rose(rsp.valid), $past(ctl.commit))
	// no commit while the scan is still running
	`LKVC_ASSERT_IMP(a_commit_after_scan, ctl.commit, !ctl.scan)

endmodule

// ----- dv/lru_key_value_cache_checker.sv -----
// ----------------------------------------------------------------------------
// lru key-value cache checker
// watches the request, response and capacity channels, keeps its own copy of
// the cache contents and recency order, and compares each response in order
// ----------------------------------------------------------------------------
module lru_key_value_cache_checker import lkvc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	lkvc_req_if  req,
	lkvc_rsp_if  rsp,
	lkvc_cfg_if  cfg,
	output int   errors,
	output int   reads_pending,
	output int   reads_hit,
	output int   reads_missed,
	output int   writes_seen
);

	typedef struct packed {
		logic              hit;
		logic [DATA_W-1:0] value;
	} read_result_t;

	read_result_t      expected_reads[$];
	logic              mirror_valid [ENTRIES];
	logic [KEY_W-1:0]  mirror_key [ENTRIES];
	logic [DATA_W-1:0] mirror_data [ENTRIES];
	logic [AGE_W-1:0]  mirror_age [ENTRIES];
	int                mirror_count = 0;
	logic [CAP_W-1:0]  mirror_capacity = CAP_RESET;
	int                error_count = 0;
	int                hit_count = 0;
	int                miss_count = 0;
	int                put_count = 0;
	int                pending_count = 0;

	assign errors        = error_count;
	assign reads_pending = pending_count;
	assign reads_hit     = hit_count;
	assign reads_missed  = miss_count;
	assign writes_seen   = put_count;

	task automatic report(string what);
		$display("%0t lkvc mismatch: %s", $time, what);
		error_count++;
	endtask

	function automatic int capacity_limit();
		int c;
		c = int'(mirror_capacity);
		if (c < 1) c = 1;
		if (c > ENTRIES) c = ENTRIES;
		return c;
	endfunction

	function automatic int find_slot(logic [KEY_W-1:0] k);
		for (int i = 0; i < ENTRIES; i++) begin
			if (mirror_valid[i] && mirror_key[i] == k) return i;
		end
		return -1;
	endfunction

	task automatic make_recent(int s);
		logic [AGE_W-1:0] a;
		a = mirror_age[s];
		for (int i = 0; i < ENTRIES; i++) begin
			if (mirror_valid[i] && mirror_age[i] < a) mirror_age[i]++;
		end
		mirror_age[s] = '0;
	endtask

	task automatic drop_oldest();
		int               victim;
		logic [AGE_W-1:0] oldest;
		victim = -1;
		oldest = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (mirror_valid[i] && (victim < 0 || mirror_age[i] > oldest)) begin
				victim = i;
				oldest = mirror_age[i];
			end
		end
		if (victim >= 0) begin
			mirror_valid[victim] = 1'b0;
			mirror_age[victim]   = '0;
			if (mirror_count > 0) mirror_count--;
		end
	endtask

	task automatic store_new(logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
		int slot;
		slot = -1;
		if (mirror_count >= capacity_limit()) drop_oldest();
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!mirror_valid[i]) slot = i;
		end
		if (slot >= 0) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (mirror_valid[i]) mirror_age[i]++;
			end
			mirror_valid[slot] = 1'b1;
			mirror_key[slot]   = k;
			mirror_data[slot]  = v;
			mirror_age[slot]   = '0;
			mirror_count++;
		end
	endtask

	task automatic model_request(op_t op, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
		int           s;
		read_result_t r;
		s = find_slot(k);
		if (op == OP_GET) begin
			if (s >= 0) begin
				make_recent(s);
				r.hit   = 1'b1;
				r.value = mirror_data[s];
				hit_count++;
			end else begin
				r.hit   = 1'b0;
				r.value = MISS_VALUE;
				miss_count++;
			end
			expected_reads.push_back(r);
		end else begin
			put_count++;
			if (s >= 0) begin
				mirror_data[s] = v;
				make_recent(s);
			end else begin
				store_new(k, v);
			end
		end
	endtask

	task automatic check_response();
		read_result_t want;
		if (expected_reads.size() == 0) begin
			report("response with no get outstanding");
		end else begin
			want = expected_reads.pop_front();
			if (rsp.hit !== want.hit)
				report($sformatf("hit flag %b, expected %b", rsp.hit, want.hit));
			if (rsp.read_value !== want.value)
				report($sformatf("read value %h, expected %h", rsp.read_value, want.value));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				mirror_valid[i] = 1'b0;
				mirror_key[i]   = '0;
				mirror_data[i]  = '0;
				mirror_age[i]   = '0;
			end
			mirror_count    = 0;
			mirror_capacity = CAP_RESET;
			expected_reads.delete();
		end else begin
			if (rsp.valid && rsp.ready) check_response();
			if (cfg.valid && cfg.ready) mirror_capacity = cfg.capacity_in_use;
			if (req.valid && req.ready) model_request(op_t'(req.cmd), req.key, req.write_value);
		end
		pending_count = expected_reads.size();
	end

endmodule

// ----- dv/lru_key_value_cache_test.sv -----
// ----------------------------------------------------------------------------
// lru key-value cache testbench
// directed gets and puts on key and value extremes, then random phases at
// several capacities with bursty requests and a stalling response side
// ----------------------------------------------------------------------------
module lru_key_value_cache_test import lkvc_pkg::*; ();

	localparam int PHASE_COUNT = 10;
	localparam int PHASE_ITEMS = 85;
	localparam int POOL_MAX    = 20;
	localparam int SETTLE      = 30;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lkvc_req_if req();
	lkvc_rsp_if rsp();
	lkvc_cfg_if cfg();

	int errors;
	int reads_pending;
	int reads_hit;
	int reads_missed;
	int writes_seen;

	int          requests_sent = 0;
	int          settings_used = 0;
	int          burst_left = 0;
	int          gap_max = 0;
	logic [15:0] stall_pattern = '1;
	logic [3:0]  stall_phase = '0;
	logic [31:0] key_pool [POOL_MAX];

	lru_key_value_cache i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	lru_key_value_cache_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.rsp           (rsp),
		.cfg           (cfg),
		.errors        (errors),
		.reads_pending (reads_pending),
		.reads_hit     (reads_hit),
		.reads_missed  (reads_missed),
		.writes_seen   (writes_seen)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(negedge clk) begin
		rsp.ready   <= stall_pattern[stall_phase];
		stall_phase <= stall_phase + 1'b1;
	end

	initial begin
		#(400_000 * 12);
		$display("timeout: responses still outstanding");
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic send_request(op_t op, logic [31:0] k, logic [31:0] v);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if (gap_max > 0) begin
				@(negedge clk);
				req.valid <= 1'b0;
				repeat ($urandom_range(0, gap_max - 1)) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		req.valid       <= 1'b1;
		req.cmd         <= op;
		req.key         <= k;
		req.write_value <= v;
		do @(posedge clk); while (!req.ready);
		requests_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		req.valid <= 1'b0;
		burst_left = 0;
		while (reads_pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] c);
		@(negedge clk);
		cfg.valid           <= 1'b1;
		cfg.capacity_in_use <= c;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
		settings_used++;
	endtask

	task automatic pick_idling();
		case ($urandom_range(0, 3))
			0: stall_pattern = '1;
			1: stall_pattern = 16'($urandom) | 16'h0001;
			2: stall_pattern = 16'($urandom | $urandom) | 16'h0001;
			default: stall_pattern = 16'($urandom & $urandom) | 16'h0001;
		endcase
		gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
	endtask

	task automatic run_phase(logic [CAP_W-1:0] c);
		int   limit;
		int   pool_size;
		op_t  op;
		logic [31:0] k;
		drain();
		write_capacity(c);
		pick_idling();
		limit = (c < 1) ? 1 : ((c > ENTRIES) ? ENTRIES : int'(c));
		pool_size = limit + $urandom_range(1, 4);
		for (int i = 0; i < pool_size; i++) key_pool[i] = $urandom;
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			op = ($urandom_range(0, 99) < 45) ? OP_GET : OP_PUT;
			k  = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, pool_size - 1)];
			send_request(op, k, $urandom);
		end
	endtask

	initial begin
		logic [CAP_W-1:0] phase_caps [PHASE_COUNT];
		req.valid           = 1'b0;
		req.cmd             = OP_GET;
		req.key             = '0;
		req.write_value     = '0;
		rsp.ready           = 1'b0;
		cfg.valid           = 1'b0;
		cfg.capacity_in_use = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part at reset capacity, no idling
		send_request(OP_GET, 32'h0000_0000, 32'h0);
		send_request(OP_PUT, 32'h0000_0000, 32'h8000_0000);
		send_request(OP_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send_request(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
		send_request(OP_GET, 32'hFFFF_FFFF, 32'h0);
		send_request(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
		send_request(OP_GET, 32'h0000_0000, 32'h0);
		send_request(OP_GET, 32'h1234_5678, 32'h0);
		for (int i = 1; i <= 4; i++) send_request(OP_PUT, i, 32'(i * 1111));

		// capacity lowered below occupancy
		drain();
		write_capacity(5'd2);
		send_request(OP_PUT, 32'd5, 32'h5555_5555);
		send_request(OP_PUT, 32'd6, 32'hAAAA_AAAA);
		send_request(OP_GET, 32'h0000_0000, 32'h0);
		send_request(OP_GET, 32'hFFFF_FFFF, 32'h0);
		for (int i = 1; i <= 6; i++) send_request(OP_GET, i, 32'h0);

		phase_caps = '{5'd0, 5'd1, 5'd31, 5'd16, 5'd3, 5'd17, 5'd8, 5'd2,
			5'($urandom_range(0, 31)), 5'($urandom_range(1, 16))};
		for (int p = 0; p < PHASE_COUNT; p++) run_phase(phase_caps[p]);

		drain();
		$display("covered %0d requests: %0d puts, %0d gets (%0d hits, %0d misses)",
			requests_sent, writes_seen, reads_hit + reads_missed, reads_hit, reads_missed);
		$display("over %0d capacity settings including 0, 1, 16 and 31", settings_used);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
